// ===== src/rvie_pkg.sv =====
// rvie_pkg: shared types and encodings for the rv32i integer execute block
// no dependencies; imported by rvie_exec, rv32i_integer_execute and tb
package rvie_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int CFG_IW    = 4;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_START_ADDRESS = 4'd0;
  localparam logic [CFG_IW-1:0] CFG_HALT_ADDRESS  = 4'd1;

  // major opcodes
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  // alu funct3
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SLT = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR  = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_BLT = 3'd4;
  localparam logic [2:0] F3_BGE = 3'd5;

  // widest funct3 that loads and stores accept
  localparam logic [2:0] F3_MEM_MAX = 3'd2;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              we;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   value;
    logic              taken;
    logic              illegal;
  } exec_res_t;

endpackage

// ===== src/rvie_exec.sv =====
// rvie_exec: decode, alu, branch compare and next pc for one instruction
// depends on rvie_pkg
module rvie_exec
  import rvie_pkg::*;
(
  input  logic [31:0]     instr,
  input  logic [XLEN-1:0] pc,
  input  logic [XLEN-1:0] op_a,
  input  logic [XLEN-1:0] op_b,
  output exec_res_t       res
);

  logic [6:0]        opc;
  logic [2:0]        f3;
  logic [REG_AW-1:0] rd;
  logic              alt;
  logic [XLEN-1:0]   imm_i;
  logic [XLEN-1:0]   imm_j;
  logic [XLEN-1:0]   imm_b;
  logic [XLEN-1:0]   alu_b;
  logic [XLEN-1:0]   alu_res;
  logic              alu_ok;
  logic              is_reg;
  logic [4:0]        sh;
  logic [XLEN-1:0]   pc_plus4;
  logic [XLEN-1:0]   next;
  logic [XLEN-1:0]   value;
  logic              writes;
  logic              taken;
  logic              bad;

  assign opc   = instr[6:0];
  assign f3    = instr[14:12];
  assign rd    = instr[11:7];
  assign alt   = |instr[31:25];
  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign is_reg = (opc == OPC_OP);
  assign alu_b  = is_reg ? op_b : imm_i;
  assign sh     = alu_b[4:0];
  assign pc_plus4 = pc + 32'd4;

  always_comb begin
    alu_ok  = 1'b1;
    alu_res = '0;
    unique case (f3)
      F3_ADD:  alu_res = (is_reg && alt) ? op_a - alu_b : op_a + alu_b;
      F3_SLL:  alu_res = op_a << sh;
      F3_XOR:  alu_res = op_a ^ alu_b;
      F3_SR:   alu_res = alt ? XLEN'($signed(op_a) >>> sh) : op_a >> sh;
      F3_OR:   alu_res = op_a | alu_b;
      F3_AND:  alu_res = op_a & alu_b;
      F3_SLT, F3_SLTU: alu_ok = 1'b0;
      default: alu_ok = 1'b0;
    endcase
  end

  always_comb begin
    next   = pc_plus4;
    value  = '0;
    writes = 1'b0;
    taken  = 1'b0;
    bad    = 1'b0;
    unique case (opc)
      OPC_OPIMM, OPC_OP: begin
        value  = alu_res;
        writes = alu_ok;
        bad    = !alu_ok;
      end
      OPC_LUI: begin
        value  = {instr[31:12], 12'd0};
        writes = 1'b1;
      end
      OPC_JAL: begin
        value  = pc_plus4;
        writes = 1'b1;
        taken  = 1'b1;
        next   = pc + imm_j;
      end
      OPC_JALR: begin
        if (f3 != F3_ADD) begin
          bad = 1'b1;
        end else begin
          value  = pc_plus4;
          writes = 1'b1;
          taken  = 1'b1;
          next   = (op_a + imm_i) & ~32'd1;
        end
      end
      OPC_BRANCH: begin
        unique case (f3)
          F3_BEQ:  taken = (op_a == op_b);
          F3_BNE:  taken = (op_a != op_b);
          F3_BLT:  taken = ($signed(op_a) < $signed(op_b));
          F3_BGE:  taken = !($signed(op_a) < $signed(op_b));
          default: bad = 1'b1;
        endcase
        if (taken) begin
          next = pc + imm_b;
        end
      end
      OPC_LOAD, OPC_STORE: bad = (f3 > F3_MEM_MAX);
      default: bad = 1'b1;
    endcase

    // unsupported encodings leave all state alone
    if (bad) begin
      next   = pc;
      writes = 1'b0;
      taken  = 1'b0;
    end
    if (rd == '0) begin
      writes = 1'b0;
    end

    res.next_pc = next;
    res.we      = writes;
    res.rd      = writes ? rd : '0;
    res.value   = writes ? value : '0;
    res.taken   = taken;
    res.illegal = bad;
  end

endmodule

// ===== src/rv32i_integer_execute.sv =====
// rv32i_integer_execute: executes one rv32i instruction word per clock while out_stall is low.
// Each accepted word has its register operands read from a 32-entry register file (with
// bypass of the word executing in the same cycle) into an operand stage; once the output
// register is free it is executed and its result lands in the output register while the
// register file and pc are updated. A new word is taken every cycle while out_stall is low;
// the rate is set by the single execute pass over the operand stage. The register file reads
// as zero after reset through per-entry valid bits, so no clearing pass is needed. Writing
// start_address also loads the pc. Depends on rvie_pkg and rvie_exec.
module rv32i_integer_execute
  import rvie_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // instruction words
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_instruction,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [XLEN-1:0]   out_next_pc,
  output logic              out_write_enable,
  output logic [REG_AW-1:0] out_write_register,
  output logic [XLEN-1:0]   out_write_value,
  output logic              out_branch_taken,
  output logic              out_illegal,
  output logic              out_halted,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [XLEN-1:0]   cfg_data
);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;

  logic                 s1_valid_r;
  logic [31:0]          instr_r;
  logic [XLEN-1:0]      rd_a_r;
  logic [XLEN-1:0]      rd_b_r;
  logic                 vld_a_r;
  logic                 vld_b_r;
  logic                 hit_a_r;
  logic                 hit_b_r;
  logic [XLEN-1:0]      byp_r;

  logic [XLEN-1:0]      pc_r;
  logic [XLEN-1:0]      halt_r;
  logic                 out_valid_r;

  logic                 accept;
  logic                 exec_fire;
  logic                 cfg_write;
  logic [REG_AW-1:0]    rs1;
  logic [REG_AW-1:0]    rs2;
  logic [XLEN-1:0]      op_a;
  logic [XLEN-1:0]      op_b;
  exec_res_t            res;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign exec_fire = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !exec_fire;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign rs1 = in_instruction[19:15];
  assign rs2 = in_instruction[24:20];

  // x0 is never written, so its valid bit stays clear and it reads zero
  assign op_a = hit_a_r ? byp_r : (vld_a_r ? rd_a_r : '0);
  assign op_b = hit_b_r ? byp_r : (vld_b_r ? rd_b_r : '0);

  rvie_exec u_exec (
    .instr (instr_r),
    .pc    (pc_r),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (res)
  );

  // register file storage
  always_ff @(posedge clk) begin
    if (exec_fire && res.we) begin
      mem[res.rd] <= res.value;
    end
    if (accept) begin
      rd_a_r <= mem[rs1];
      rd_b_r <= mem[rs2];
    end
  end

  // operand stage payload, with bypass of the word retiring this cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      instr_r <= in_instruction;
      vld_a_r <= valid_r[rs1];
      vld_b_r <= valid_r[rs2];
      hit_a_r <= exec_fire && res.we && (res.rd == rs1);
      hit_b_r <= exec_fire && res.we && (res.rd == rs2);
      byp_r   <= res.value;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_next_pc        <= res.next_pc;
      out_write_enable   <= res.we;
      out_write_register <= res.rd;
      out_write_value    <= res.value;
      out_branch_taken   <= res.taken;
      out_illegal        <= res.illegal;
      out_halted         <= (res.next_pc == halt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      halt_r      <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (exec_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (exec_fire && res.we) begin
        valid_r[res.rd] <= 1'b1;
      end
      priority if (cfg_write && cfg_index == CFG_START_ADDRESS) begin
        pc_r <= cfg_data;
      end else if (exec_fire) begin
        pc_r <= res.next_pc;
      end
      if (cfg_write && cfg_index == CFG_HALT_ADDRESS) begin
        halt_r <= cfg_data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // an unsupported word must leave the pc where it was
  a_illegal_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && res.illegal && !cfg_write |=> pc_r == $past(pc_r))
    else $error("pc moved on an illegal word");

  // a register write marks the entry as holding data
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && res.we |=> valid_r[$past(res.rd)])
    else $error("written register not marked valid");

  // x0 is never reported as written
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_write_enable && out_write_register == '0))
    else $error("write reported to x0");

  // the operand stage only refills when its word retires or it is empty
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !exec_fire |-> in_stall)
    else $error("operand stage overwritten");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for rv32i_integer_execute; predicts every retired word from its
// own register file and pc copy and checks each result field. depends on rvie_pkg and src rtl
module tb;
  import rvie_pkg::*;

  localparam logic [6:0] OPC_BAD = 7'h7F;
  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [2:0] F3_JALR = 3'd0;
  localparam logic [2:0] F3_JALR_BAD = 3'd1;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_SH   = 3'd1;
  localparam logic [2:0] F3_LBU  = 3'd4;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        we;
    logic [4:0]  rd;
    logic [31:0] value;
    logic        taken;
    logic        illegal;
    logic        halted;
  } retire_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [31:0]       in_instruction = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [XLEN-1:0]   out_next_pc;
  logic              out_write_enable;
  logic [REG_AW-1:0] out_write_register;
  logic [XLEN-1:0]   out_write_value;
  logic              out_branch_taken;
  logic              out_illegal;
  logic              out_halted;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index      = '0;
  logic [XLEN-1:0]   cfg_data       = '0;

  // architectural copy kept by the bench
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc    = '0;
  logic [31:0] halt_addr  = '0;

  retire_t expected_retires [$];
  int      error_count = 0;
  bit      idle_on     = 1'b1;
  int      hold_cycles = 0;

  rv32i_integer_execute dut (.*);

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
  end

  // encoders
  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] off);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_u(input logic [4:0] rd, input logic [19:0] imm);
    return {imm, rd, OPC_LUI};
  endfunction

  // executes one word against the bench's state and returns what should retire
  function automatic retire_t execute_word(input logic [31:0] w);
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2, sh;
    logic [2:0]  f3;
    logic        alt, wr, tk, bad;
    logic [31:0] a, b, opb, imm_i, nxt, val;
    retire_t     r;
    opc   = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    rs1   = w[19:15];
    rs2   = w[24:20];
    alt   = |w[31:25];
    a     = (rs1 == 5'd0) ? 32'd0 : arch_regs[rs1];
    b     = (rs2 == 5'd0) ? 32'd0 : arch_regs[rs2];
    imm_i = {{20{w[31]}}, w[31:20]};
    nxt   = arch_pc + 32'd4;
    val   = '0;
    wr    = 1'b0;
    tk    = 1'b0;
    bad   = 1'b0;
    case (opc)
      OPC_OPIMM, OPC_OP: begin
        opb = (opc == OPC_OP) ? b : imm_i;
        sh  = opb[4:0];
        wr  = 1'b1;
        case (f3)
          F3_ADD: begin
            if (opc == OPC_OP && alt) val = a - opb;
            else val = a + opb;
          end
          F3_SLL: val = a << sh;
          F3_XOR: val = a ^ opb;
          F3_SR: begin
            if (alt) val = $signed(a) >>> sh;
            else val = a >> sh;
          end
          F3_OR:  val = a | opb;
          F3_AND: val = a & opb;
          default: begin
            wr  = 1'b0;
            bad = 1'b1;
          end
        endcase
      end
      OPC_LUI: begin
        val = {w[31:12], 12'h000};
        wr  = 1'b1;
      end
      OPC_JAL: begin
        val = arch_pc + 32'd4;
        wr  = 1'b1;
        tk  = 1'b1;
        nxt = arch_pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR: begin
        if (f3 != F3_JALR) begin
          bad = 1'b1;
        end else begin
          val = arch_pc + 32'd4;
          wr  = 1'b1;
          tk  = 1'b1;
          nxt = (a + imm_i) & ~32'd1;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  tk = (a == b);
          F3_BNE:  tk = (a != b);
          F3_BLT:  tk = ($signed(a) < $signed(b));
          F3_BGE:  tk = !($signed(a) < $signed(b));
          default: bad = 1'b1;
        endcase
        if (tk) nxt = arch_pc + {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      OPC_LOAD, OPC_STORE: bad = (f3 > F3_MEM_MAX);
      default: bad = 1'b1;
    endcase
    if (bad) begin
      nxt = arch_pc;
      wr  = 1'b0;
      tk  = 1'b0;
    end
    if (rd == 5'd0) wr = 1'b0;
    if (wr) arch_regs[rd] = val;
    arch_pc   = nxt;
    r.next_pc = nxt;
    r.we      = wr;
    r.rd      = wr ? rd : 5'd0;
    r.value   = wr ? val : 32'd0;
    r.taken   = tk;
    r.illegal = bad;
    r.halted  = (nxt == halt_addr);
    return r;
  endfunction

  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'($urandom);
    return 5'($urandom_range(0, 7));
  endfunction

  // mostly well-formed words with random content, the rest raw noise
  function automatic logic [31:0] random_word();
    int          pick;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] imm;
    logic [12:0] boff;
    logic [20:0] joff;
    pick = $urandom_range(0, 99);
    f3   = 3'($urandom);
    case ($urandom_range(0, 7))
      0:       imm = 12'h7FF;
      1:       imm = 12'h800;
      default: imm = 12'($urandom);
    endcase
    if ($urandom_range(0, 1) == 0) f7 = F7_ZERO;
    else if ($urandom_range(0, 3) == 0) f7 = 7'($urandom);
    else f7 = F7_ALT;
    if (pick < 30) begin
      if (f3 == F3_SR || f3 == F3_SLL) imm = {f7, 5'($urandom)};
      return enc_i(OPC_OPIMM, f3, pick_reg(), pick_reg(), imm);
    end
    if (pick < 55) return enc_r(f7, f3, pick_reg(), pick_reg(), pick_reg());
    if (pick < 62) return enc_u(pick_reg(), 20'($urandom));
    if (pick < 72) begin
      case ($urandom_range(0, 4))
        0: f3 = F3_BEQ;
        1: f3 = F3_BNE;
        2: f3 = F3_BLT;
        3: f3 = F3_BGE;
        default: ;
      endcase
      if ($urandom_range(0, 5) == 0) boff = 13'($urandom);
      else boff = 13'($urandom_range(0, 16) * 4 - 32);
      return enc_b(f3, pick_reg(), pick_reg(), boff);
    end
    if (pick < 78) begin
      if ($urandom_range(0, 5) == 0) joff = 21'($urandom);
      else joff = 21'($urandom_range(0, 16) * 4 - 32);
      return enc_j(pick_reg(), joff);
    end
    if (pick < 84) begin
      if ($urandom_range(0, 4) != 0) f3 = F3_JALR;
      return enc_i(OPC_JALR, f3, pick_reg(), pick_reg(), imm);
    end
    if (pick < 90) begin
      return enc_i(($urandom_range(0, 1) == 0) ? OPC_LOAD : OPC_STORE,
                   3'($urandom_range(0, 3)), pick_reg(), pick_reg(), imm);
    end
    return $urandom;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) flag_error($sformatf("%s expected %h got %h", name, want, got));
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    retire_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_retires.size() == 0) begin
        flag_error($sformatf("result with none pending, next_pc %h", out_next_pc));
      end else begin
        want = expected_retires.pop_front();
        compare_field("next_pc", want.next_pc, out_next_pc);
        compare_field("write_enable", 32'(want.we), 32'(out_write_enable));
        compare_field("write_register", 32'(want.rd), 32'(out_write_register));
        compare_field("write_value", want.value, out_write_value);
        compare_field("branch_taken", 32'(want.taken), 32'(out_branch_taken));
        compare_field("illegal", 32'(want.illegal), 32'(out_illegal));
        compare_field("halted", 32'(want.halted), 32'(out_halted));
      end
    end
  end

  // receiver stalls: random bursts, or a long hold when one is requested
  initial begin : result_stalls
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [31:0] w);
    in_valid       <= 1'b1;
    in_instruction <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_retires.push_back(execute_word(w));
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_retires.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // a start address write also reloads the pc
    if (idx == CFG_START_ADDRESS) arch_pc = data;
    else if (idx == CFG_HALT_ADDRESS) halt_addr = data;
  endtask

  task automatic test_alu();
    write_cfg(CFG_START_ADDRESS, 32'h0000_0100);
    write_cfg(CFG_HALT_ADDRESS, 32'h0000_0108);
    send_word(enc_u(5'd1, 20'h80000));
    send_word(enc_i(OPC_OPIMM, F3_ADD, 5'd2, 5'd0, 12'hFFF));   // lands on halt address
    send_word(enc_i(OPC_OPIMM, F3_SR, 5'd3, 5'd1, {F7_ALT, 5'd31}));
    send_word(enc_i(OPC_OPIMM, F3_SR, 5'd4, 5'd1, {F7_ZERO, 5'd31}));
    send_word(enc_i(OPC_OPIMM, F3_SLL, 5'd5, 5'd2, {7'h7F, 5'd31}));
    send_word(enc_i(OPC_OPIMM, F3_ADD, 5'd6, 5'd0, 12'h7FF));
    send_word(enc_r(F7_ALT, F3_ADD, 5'd7, 5'd1, 5'd4));
    send_word(enc_r(7'h01, F3_SR, 5'd8, 5'd1, 5'd2));        // odd funct7 still arithmetic
    send_word(enc_r(7'h55, F3_SLL, 5'd9, 5'd4, 5'd2));
    send_word(enc_i(OPC_OPIMM, F3_XOR, 5'd0, 5'd2, 12'h555)); // x0 write dropped
  endtask

  task automatic test_control_flow();
    write_cfg(CFG_START_ADDRESS, 32'h0000_2000);
    write_cfg(CFG_HALT_ADDRESS, 32'h0000_0000);
    send_word(enc_j(5'd10, -21'sd8));
    send_word(enc_i(OPC_JALR, F3_JALR, 5'd6, 5'd6, 12'h000)); // odd target, rd equals rs1
    send_word(enc_b(F3_BEQ, 5'd2, 5'd3, 13'd12));
    send_word(enc_b(F3_BNE, 5'd2, 5'd3, 13'd12));
    send_word(enc_b(F3_BLT, 5'd1, 5'd4, 13'h1000));
    send_word(enc_b(F3_BGE, 5'd1, 5'd4, 13'd8));
    send_word(enc_b(F3_BGE, 5'd4, 5'd4, 13'd2));
    send_word(enc_j(5'd0, 21'h0FFFFE));
  endtask

  task automatic test_illegal_encodings();
    send_word(enc_i(OPC_BAD, F3_ADD, 5'd11, 5'd1, 12'h123));
    send_word(enc_i(OPC_OPIMM, F3_SLT, 5'd11, 5'd1, 12'h001));
    send_word(enc_r(F7_ZERO, F3_SLTU, 5'd11, 5'd1, 5'd2));
    send_word(enc_b(F3_BLTU, 5'd1, 5'd2, 13'd16));
    send_word(enc_i(OPC_JALR, F3_JALR_BAD, 5'd11, 5'd1, 12'h010));
    send_word(enc_i(OPC_LOAD, F3_LBU, 5'd11, 5'd1, 12'h000));
    send_word(enc_i(OPC_LOAD, F3_LW, 5'd11, 5'd1, 12'h004));
    send_word(enc_i(OPC_STORE, F3_SH, 5'd11, 5'd1, 12'h008));
  endtask

  task automatic test_address_extremes();
    write_cfg(CFG_START_ADDRESS, 32'hFFFF_FFFC);
    send_word(enc_i(OPC_OPIMM, F3_ADD, 5'd12, 5'd0, 12'h001)); // pc wraps to zero
    send_word(enc_i(OPC_BAD, F3_ADD, 5'd12, 5'd0, 12'h001));
    write_cfg(CFG_START_ADDRESS, 32'hFFFF_FFFF);
    write_cfg(CFG_HALT_ADDRESS, 32'hFFFF_FFFF);
    send_word(enc_i(OPC_BAD, F3_ADD, 5'd12, 5'd0, 12'h001));
    send_word(enc_i(OPC_OPIMM, F3_ADD, 5'd12, 5'd0, 12'h001));
  endtask

  task automatic test_random_programs();
    logic [31:0] base;
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: base = 32'h0000_0000;
        1: base = 32'hFFFF_FFF0;
        2: base = $urandom & ~32'd3;
        default: base = $urandom;
      endcase
      write_cfg(CFG_START_ADDRESS, base);
      if (p % 5 == 4) write_cfg(CFG_HALT_ADDRESS, $urandom);
      else write_cfg(CFG_HALT_ADDRESS, base + 32'd4 * $urandom_range(1, 6));
      repeat (50) send_word(random_word());
    end
  endtask

  task automatic test_backpressure();
    write_cfg(CFG_START_ADDRESS, 32'h0000_4000);
    write_cfg(CFG_HALT_ADDRESS, 32'h0000_4040);
    idle_on = 1'b0;
    hold_cycles = 64;
    repeat (30) send_word(random_word());
    idle_on = 1'b1;
    // sender waits for every pending word before going on
    drain();
    repeat (30) send_word(random_word());
  endtask

  task automatic test_unthrottled();
    idle_on = 1'b0;
    repeat (200) send_word(random_word());
  endtask

  initial begin : main_sequence
    int guard;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alu();
    test_control_flow();
    test_illegal_encodings();
    test_address_extremes();
    test_random_programs();
    test_backpressure();
    test_unthrottled();
    in_valid <= 1'b0;
    guard = 0;
    while (expected_retires.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_retires.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/rvie_pkg.sv
src/rvie_exec.sv
src/rv32i_integer_execute.sv
bench/tb.sv
